/* rtl/quaternion_to_euler_angles_core_assert.svh */
// Assertion macros for the quaternion to Euler angle core.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// Same-cycle implication.
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/q2e_pkg.sv */
// Shared types, widths and constants of the quaternion to Euler angle core.
// No dependencies.
package q2e_pkg;

  localparam int unsigned WW       = 64;  // wide datapath
  localparam int unsigned ZW       = 34;  // angle accumulator, 2^-30 rad
  localparam int unsigned ATAN_LEN = 30;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic               quat_present;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } q2e_in_t;

  typedef struct packed {
    logic signed [14:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [15:0] yaw_deg;
  } q2e_out_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd7;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/quaternion_to_euler_angles_core.sv */
// Quaternion (Q30) to pitch, roll and yaw in 1/2^ANGLE_FRAC_BITS degree units.
// Depends on q2e_pkg, q2e_atan2 and quaternion_to_euler_angles_core_assert.svh.
//
// The core takes one quaternion per clock, unless a held result stalls it, and returns
// its angles; items without a quaternion produce no result. The pipeline holds the
// 16-stage square root that forms the pitch cosine, the 11 normalization and fold
// stages and one stage per CORDIC iteration, plus three product stages in front and
// three scaling stages behind. A result held at a stalled output freezes the whole
// pipeline and raises in_stall_o; nothing is lost or repeated.
`include "quaternion_to_euler_angles_core_assert.svh"

module quaternion_to_euler_angles_core #(
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned CORDIC_STAGES   = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  q2e_pkg::q2e_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output q2e_pkg::q2e_out_t out_data_o
);
  import q2e_pkg::*;

  localparam int unsigned NIT       = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int unsigned LANE_LAT  = 11 + NIT;
  localparam int unsigned SQ_ITERS  = 31;
  localparam int unsigned SQ_STAGES = (SQ_ITERS + 1) / 2;
  localparam int unsigned DLY       = 1 + SQ_STAGES;
  localparam int unsigned TOTAL     = 3 + SQ_STAGES + LANE_LAT + 3;
  localparam int unsigned SQW       = 62;
  localparam int unsigned KW        = 11 + ANGLE_FRAC_BITS;
  localparam int unsigned MUL_W     = ZW + KW;
  localparam int unsigned TW        = MUL_W - 30;
  localparam int unsigned QW0       = TW - 3;

  localparam logic signed [WW-1:0]    ONE_Q56  = 64'sh0100_0000_0000_0000;
  localparam logic [SQW-1:0]          ONE_Q60  = 62'h1000_0000_0000_0000;
  localparam logic signed [KW-1:0]    ANG_K    = KW'(573 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [MUL_W-1:0] HALF_DEN = MUL_W'(64'sd5 <<< 30);
  localparam logic [20:0]             RECIP10  = 21'd1677722;

  typedef struct packed {
    logic signed [31:0]   s30;
    logic signed [WW-1:0] rn;
    logic signed [WW-1:0] rd;
    logic signed [WW-1:0] yn;
    logic signed [WW-1:0] yd;
  } dly_t;

  logic             en;
  logic [TOTAL-1:0] vld_q;

  // Advance everything unless a finished result is held
  assign en         = !(vld_q[TOTAL-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL-2:0], in_valid_i && in_data_i.quat_present};
    end
  end

  // Stage A: component products, Q60
  logic signed [WW-1:0] p_wy_q, p_xz_q, p_yz_q, p_wx_q, p_xx_q;
  logic signed [WW-1:0] p_yy_q, p_xy_q, p_wz_q, p_ww_q, p_zz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wy_q <= in_data_i.quat_w * in_data_i.quat_y;
      p_xz_q <= in_data_i.quat_x * in_data_i.quat_z;
      p_yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      p_wx_q <= in_data_i.quat_w * in_data_i.quat_x;
      p_xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      p_yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      p_xy_q <= in_data_i.quat_x * in_data_i.quat_y;
      p_wz_q <= in_data_i.quat_w * in_data_i.quat_z;
      p_ww_q <= in_data_i.quat_w * in_data_i.quat_w;
      p_zz_q <= in_data_i.quat_z * in_data_i.quat_z;
    end
  end

  // Stage B: Q56 sums, clamp the asin argument
  logic signed [WW-1:0] s_full, s_clamp;
  dly_t                 b_d, b_q;

  always_comb begin
    s_full = ((p_wy_q >>> 4) - (p_xz_q >>> 4)) <<< 1;
    if (s_full > ONE_Q56) begin
      s_clamp = ONE_Q56;
    end else if (s_full < -ONE_Q56) begin
      s_clamp = -ONE_Q56;
    end else begin
      s_clamp = s_full;
    end
    // +-2^30 needs 32 bits after the shift
    b_d.s30 = $signed(s_clamp[57:26]);
    b_d.rn  = ((p_yz_q >>> 4) + (p_wx_q >>> 4)) <<< 1;
    b_d.rd  = ONE_Q56 - (((p_xx_q >>> 4) + (p_yy_q >>> 4)) <<< 1);
    b_d.yn  = ((p_xy_q >>> 4) + (p_wz_q >>> 4)) <<< 1;
    b_d.yd  = (p_ww_q >>> 4) + (p_xx_q >>> 4) - (p_yy_q >>> 4) - (p_zz_q >>> 4);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= b_d;
    end
  end

  // Stage C: radicand 2^60 - s^2; delay line holds the other operands alongside
  logic signed [61:0] s_sq;
  logic [SQW-1:0]     rad_q;
  dly_t               dl_q [DLY];

  assign s_sq = b_q.s30 * b_q.s30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= ONE_Q60 - $unsigned(s_sq);
      dl_q[0] <= b_q;
      for (int d = 1; d < DLY; d++) begin
        dl_q[d] <= dl_q[d-1];
      end
    end
  end

  // Square root, two result bits per stage and one in the last stage
  function automatic logic [2*SQW-1:0] sq_iter(input logic [SQW-1:0] n,
                                               input logic [SQW-1:0] r,
                                               input int unsigned j);
    logic [SQW-1:0] bitv, nn, rr;
    bitv = SQW'(1) << (60 - 2 * j);
    if (n >= r + bitv) begin
      nn = n - (r + bitv);
      rr = (r >> 1) + bitv;
    end else begin
      nn = n;
      rr = r >> 1;
    end
    return {nn, rr};
  endfunction

  logic [SQW-1:0] sqn_q [SQ_STAGES];
  logic [SQW-1:0] sqr_q [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [SQW-1:0] nin, rin, nmid, rmid, nout, rout;

    if (k == 0) begin : g_first
      assign nin = rad_q;
      assign rin = '0;
    end else begin : g_next
      assign nin = sqn_q[k-1];
      assign rin = sqr_q[k-1];
    end

    assign {nmid, rmid} = sq_iter(nin, rin, 2 * k);

    if (2 * k + 1 < SQ_ITERS) begin : g_two
      assign {nout, rout} = sq_iter(nmid, rmid, 2 * k + 1);
    end else begin : g_one
      assign nout = nmid;
      assign rout = rmid;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqn_q[k] <= nout;
        sqr_q[k] <= rout;
      end
    end
  end

  // Three atan2 lanes: pitch, roll, yaw
  logic signed [WW-1:0] lane_y [3];
  logic signed [WW-1:0] lane_x [3];
  logic signed [ZW-1:0] lane_z [3];

  assign lane_y[0] = {{(WW-32){dl_q[DLY-1].s30[31]}}, dl_q[DLY-1].s30};
  assign lane_x[0] = {{(WW-SQW){1'b0}}, sqr_q[SQ_STAGES-1]};
  assign lane_y[1] = dl_q[DLY-1].rn;
  assign lane_x[1] = dl_q[DLY-1].rd;
  assign lane_y[2] = dl_q[DLY-1].yn;
  assign lane_x[2] = dl_q[DLY-1].yd;

  logic signed [15:0] ang_q [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam logic signed [ZW-1:0] BOUND = (l == 0) ? HALF_PI_Q30 : PI_Q30;
    localparam int unsigned          FW    = (l == 0) ? 15 : 16;
    localparam logic signed [31:0]   HI    = 32'sd1 <<< (FW - 1);

    logic signed [ZW-1:0]    zc;
    logic signed [MUL_W-1:0] prod_q, num;
    logic signed [TW-1:0]    t;
    logic [TW-1:0]           u;
    logic [TW+20:0]          rp;
    logic [QW0-1:0]          q0_q;
    logic                    neg_q;
    logic signed [31:0]      qe;
    logic signed [15:0]      sat;

    q2e_atan2 #(
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_atan2 (
      .clk_i (clk_i),
      .en_i  (en),
      .y_i   (lane_y[l]),
      .x_i   (lane_x[l]),
      .z_o   (lane_z[l])
    );

    // Clamp the angle and scale by 57.3 * 2^ANGLE_FRAC_BITS * 10
    always_comb begin
      if (lane_z[l] > BOUND) begin
        zc = BOUND;
      end else if (lane_z[l] < -BOUND) begin
        zc = -BOUND;
      end else begin
        zc = lane_z[l];
      end
    end

    // Round, drop 2^30, floor-divide by ten through a reciprocal on the magnitude
    assign num = prod_q + HALF_DEN;
    assign t   = $signed(num[MUL_W-1:30]);
    assign u   = t[TW-1] ? ~t : t;
    assign rp  = u * RECIP10;

    // Restore the sign and saturate to the field
    always_comb begin
      qe = neg_q ? ~(32'sd0 + $signed({1'b0, q0_q})) : $signed({1'b0, q0_q});
      if (qe > HI - 32'sd1) begin
        sat = 16'(HI - 32'sd1);
      end else if (qe < -HI) begin
        sat = 16'(-HI);
      end else begin
        sat = qe[15:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q   <= zc * ANG_K;
        q0_q     <= rp[TW+20:24];
        neg_q    <= t[TW-1];
        ang_q[l] <= sat;
      end
    end
  end

  assign out_valid_o          = vld_q[TOTAL-1];
  assign out_data_o.pitch_deg = ang_q[0][14:0];
  assign out_data_o.roll_deg  = ang_q[1];
  assign out_data_o.yaw_deg   = ang_q[2];

  `Q2E_ASSERT_IMP(a_out_hold_stalls_in, out_valid_o && out_stall_i, in_stall_o,
                  "output held but input not stalled")
  `Q2E_ASSERT_NXT(a_pipe_frozen, in_stall_o, $stable(vld_q),
                  "pipeline moved while stalled")
  `Q2E_ASSERT_NXT(a_absent_no_item,
                  in_valid_i && !in_stall_o && !in_data_i.quat_present, !vld_q[0],
                  "item without quaternion entered pipeline")

endmodule

/* rtl/q2e_atan2.sv */
// Pipelined atan2 lane: operand normalization, quadrant fold and CORDIC vectoring.
// Depends on q2e_pkg. Each normalization step, the fold and each CORDIC iteration is a register advanced by en_i.
module q2e_atan2 #(
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [q2e_pkg::WW-1:0] y_i,
  input  logic signed [q2e_pkg::WW-1:0] x_i,
  output logic signed [q2e_pkg::ZW-1:0] z_o
);
  import q2e_pkg::*;

  localparam int unsigned NSTEP = 5;
  localparam int unsigned NORM  = 2 * NSTEP;
  localparam int unsigned NIT   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int unsigned CW    = 36;
  localparam logic signed [WW-1:0] LIM_HI = 64'sh0000_0000_8000_0000;

  function automatic logic signed [WW-1:0] mag_f(input logic signed [WW-1:0] v);
    return v[WW-1] ? -v : v;
  endfunction

  logic signed [WW-1:0] nx_q [NORM];
  logic signed [WW-1:0] ny_q [NORM];
  logic                 nz_q [NORM];

  // Normalize: right steps bring the larger magnitude below 2^31, left steps to 2^30 or above
  for (genvar k = 0; k < NORM; k++) begin : g_norm
    localparam int unsigned SH = 1 << (NSTEP - 1 - (k % NSTEP));
    logic signed [WW-1:0] xin, yin, xn, yn, mx, my;
    logic                 zin;

    if (k == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = (x_i == '0) && (y_i == '0);
    end else begin : g_next
      assign xin = nx_q[k-1];
      assign yin = ny_q[k-1];
      assign zin = nz_q[k-1];
    end

    if (k < NSTEP) begin : g_right
      logic signed [WW-1:0] tx, ty;

      always_comb begin
        tx = xin >>> (SH - 1);
        ty = yin >>> (SH - 1);
        mx = mag_f(tx);
        my = mag_f(ty);
        if ((mx >= LIM_HI) || (my >= LIM_HI)) begin
          xn = xin >>> SH;
          yn = yin >>> SH;
        end else begin
          xn = xin;
          yn = yin;
        end
      end
    end else begin : g_left
      always_comb begin
        mx = mag_f(xin);
        my = mag_f(yin);
        if ((mx < (64'sd1 <<< (31 - SH))) && (my < (64'sd1 <<< (31 - SH)))) begin
          xn = xin <<< SH;
          yn = yin <<< SH;
        end else begin
          xn = xin;
          yn = yin;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k] <= xn;
        ny_q[k] <= yn;
        nz_q[k] <= zin;
      end
    end
  end

  logic signed [CW-1:0] cx_q [NIT+1];
  logic signed [CW-1:0] cy_q [NIT+1];
  logic signed [ZW-1:0] cz_q [NIT+1];
  logic                 cf_q [NIT+1];

  // Fold the left half plane onto the right half plane
  logic signed [CW-1:0] fx, fy, px_d, py_d;
  logic signed [ZW-1:0] pz_d;

  always_comb begin
    fx = $signed(nx_q[NORM-1][CW-1:0]);
    fy = $signed(ny_q[NORM-1][CW-1:0]);
    if (fx < 0) begin
      if (fy >= 0) begin
        px_d = fy;
        py_d = -fx;
        pz_d = HALF_PI_Q30;
      end else begin
        px_d = -fy;
        py_d = fx;
        pz_d = -HALF_PI_Q30;
      end
    end else begin
      px_d = fx;
      py_d = fy;
      pz_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= px_d;
      cy_q[0] <= py_d;
      cz_q[0] <= pz_d;
      cf_q[0] <= nz_q[NORM-1];
    end
  end

  // CORDIC vectoring, one micro-rotation per stage
  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic signed [ZW-1:0] ang;
    assign ang = $signed({2'b00, atan_entry(5'(i))});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + ang;
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - ang;
        end
        cf_q[i+1] <= cf_q[i];
      end
    end
  end

  // Zero vector gives zero angle
  assign z_o = cf_q[NIT] ? '0 : cz_q[NIT];

endmodule

/* bench/q2e_angle_checker.sv */
// Angle checker for the quaternion to Euler angle core: watches both channels,
// computes the expected angles in integer arithmetic and compares. Uses q2e_pkg.
`timescale 1ns / 100ps

module q2e_angle_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  q2e_pkg::q2e_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  q2e_pkg::q2e_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                angles_seen_o
);
  import q2e_pkg::*;

  localparam int FRAC_BITS = 7;
  localparam int STAGES    = 18;

  q2e_out_t angle_queue[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint prod_q56(longint a, longint b);
    return floor_shr(a * b, 4);
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_val(int i);
    longint tab [30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1};
    return tab[i];
  endfunction

  // Vectoring rotation: normalize, fold into the right half plane, iterate.
  function automatic longint vector_angle(longint y, longint x);
    longint z, m, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
    while (m >= (64'sd1 <<< 31)) begin
      x = floor_shr(x, 1);
      y = floor_shr(y, 1);
      m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
    end
    while (m < (64'sd1 <<< 30)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = 1686629713;
      end else begin
        nx = -y; ny = x; z = -1686629713;
      end
      x = nx;
      y = ny;
    end
    for (int i = 0; i < STAGES && i < 30; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i);
        ny = y - floor_shr(x, i);
        z = z + atan_val(i);
      end else begin
        nx = x - floor_shr(y, i);
        ny = y + floor_shr(x, i);
        z = z - atan_val(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // Clamp, scale to degrees with round half up, saturate to the field width.
  function automatic longint scale_deg(longint z, longint bound, int width);
    longint den, num, q, lo, hi;
    den = 64'sd10 <<< 30;
    if (z > bound) z = bound;
    if (z < -bound) z = -bound;
    num = z * 573 * (64'sd1 <<< FRAC_BITS) + den / 2;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    hi = (64'sd1 <<< (width - 1)) - 1;
    lo = -(64'sd1 <<< (width - 1));
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q;
  endfunction

  function automatic q2e_out_t predict_angles(q2e_in_t q);
    longint w, x, y, zc, s, s30, c, rn, rd, yn, yd;
    q2e_out_t r;
    w = longint'(q.quat_w);
    x = longint'(q.quat_x);
    y = longint'(q.quat_y);
    zc = longint'(q.quat_z);
    s = 2 * (prod_q56(w, y) - prod_q56(x, zc));
    if (s > (64'sd1 <<< 56)) s = 64'sd1 <<< 56;
    if (s < -(64'sd1 <<< 56)) s = -(64'sd1 <<< 56);
    s30 = floor_shr(s, 26);
    c = int_sqrt((64'd1 << 60) - longint'(s30 * s30));
    rn = 2 * (prod_q56(y, zc) + prod_q56(w, x));
    rd = (64'sd1 <<< 56) - 2 * (prod_q56(x, x) + prod_q56(y, y));
    yn = 2 * (prod_q56(x, y) + prod_q56(w, zc));
    yd = prod_q56(w, w) + prod_q56(x, x) - prod_q56(y, y) - prod_q56(zc, zc);
    r.pitch_deg = 15'(scale_deg(vector_angle(s30, c), 64'sd1686629713, 15));
    r.roll_deg  = 16'(scale_deg(vector_angle(rn, rd), 64'sd3373259426, 16));
    r.yaw_deg   = 16'(scale_deg(vector_angle(yn, yd), 64'sd3373259426, 16));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    angles_seen_o = 0;
    pending_o = 0;
  end

  // Predict on each input transfer that carries a quaternion, compare on each output transfer.
  always @(posedge clk_i) begin
    q2e_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i && in_data_i.quat_present)
        angle_queue.push_back(predict_angles(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        angles_seen_o++;
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = angle_queue.pop_front();
          if (out_data_i.pitch_deg !== want.pitch_deg)
            report_mismatch("pitch", out_data_i.pitch_deg, want.pitch_deg);
          if (out_data_i.roll_deg !== want.roll_deg)
            report_mismatch("roll", out_data_i.roll_deg, want.roll_deg);
          if (out_data_i.yaw_deg !== want.yaw_deg)
            report_mismatch("yaw", out_data_i.yaw_deg, want.yaw_deg);
        end
      end
    end
    pending_o = angle_queue.size();
  end
endmodule

/* bench/quaternion_to_euler_angles_core_tb.sv */
// Testbench top for quaternion_to_euler_angles_core: drives quaternions under
// several idle and stall patterns and gives the verdict. Uses q2e_angle_checker.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_core_tb;
  import q2e_pkg::*;

  localparam int LATENCY     = 51;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  q2e_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  q2e_out_t out_data;
  int       fail_count, pending, angles_seen;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_off = 1'b0;
  int       items_sent = 0;

  quaternion_to_euler_angles_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  q2e_angle_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .angles_seen_o(angles_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Drive the receiver stall.
  always @(posedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Pick a component: extremes, unit-ish values, zero, fully random bits or scaled random values.
  function automatic logic [31:0] rand_comp();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h4000_0000;
      3: return 32'hc000_0000;
      4: return 32'd0;
      5, 6: return $urandom;
      default: return 32'($signed($urandom_range(32'h7fff_ffff)) >>> $urandom_range(4))
        ^ {32{$urandom_range(1) == 1}};
    endcase
  endfunction

  // Offer one item and hold it until transferred.
  task automatic send_quat(logic present, logic [31:0] w, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    q2e_in_t item;
    item.quat_present = present;
    item.quat_w = w;
    item.quat_x = x;
    item.quat_y = y;
    item.quat_z = z;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_quat($urandom_range(7) != 0, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    in_valid <= 1'b0;
  endtask

  localparam logic [31:0] ONE  = 32'h4000_0000;
  localparam logic [31:0] MONE = 32'hc000_0000;
  localparam logic [31:0] HALF = 32'h2000_0000;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MAXN = 32'h8000_0000;
  localparam logic [31:0] R2   = 32'h2d41_3ccd;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, axes, gimbal lock, zero vector, extremes, no quaternion.
    send_quat(1'b1, ONE, 0, 0, 0);
    send_quat(1'b0, ONE, ONE, ONE, ONE);
    send_quat(1'b1, 0, 0, 0, 0);
    send_quat(1'b1, 0, ONE, 0, 0);
    send_quat(1'b1, 0, 0, ONE, 0);
    send_quat(1'b1, 0, 0, 0, ONE);
    send_quat(1'b1, R2, 0, R2, 0);
    send_quat(1'b1, R2, 0, MONE ^ 32'h0, 0);
    send_quat(1'b1, ONE, 0, ONE, 0);
    send_quat(1'b1, ONE, 0, MONE, 0);
    send_quat(1'b1, HALF, HALF, HALF, HALF);
    send_quat(1'b1, HALF, MONE, HALF, MONE);
    send_quat(1'b1, MAXP, MAXP, MAXP, MAXP);
    send_quat(1'b1, MAXN, MAXN, MAXN, MAXN);
    send_quat(1'b1, MAXP, MAXN, MAXP, MAXN);
    send_quat(1'b1, MAXN, MAXP, MAXN, MAXP);
    send_quat(1'b1, MONE, 0, 0, 0);
    send_quat(1'b1, 0, 0, 0, MONE);
    send_quat(1'b1, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h1);
    send_quat(1'b1, 0, ONE, ONE, 0);
    in_valid <= 1'b0;

    // Random phases over the idle and stall patterns.
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(90);
    send_idle_pct = 68; recv_stall_pct = 0;  send_random(90);
    send_idle_pct = 0;  recv_stall_pct = 68; send_random(90);
    send_idle_pct = 32; recv_stall_pct = 32; send_random(90);

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(90);
    join

    // Drain, then let the pipeline settle.
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d items, checked %0d angle sets", items_sent, angles_seen);
    $display("phases: directed, free flow, sender gaps, receiver stalls, both, hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
